@@ hdl/bmm_pkg.sv @@
`default_nettype none

package bmm_pkg;

    // Decode windows
    localparam logic [15:0] RAM_LO = 16'h0000;
    localparam logic [15:0] RAM_HI = 16'h9BFF;
    localparam logic [15:0] IO_LO  = 16'h8000;
    localparam logic [15:0] IO_HI  = 16'h9FFF;
    localparam logic [15:0] ROM_LO = 16'h8000;

    localparam logic [15:0] HOST_IO_MASK = 16'h1FFF;

    localparam logic [7:0] RAM_FILL = 8'h00;
    localparam logic [7:0] IO_FILL  = 8'h00;
    localparam logic [7:0] ROM_FILL = 8'hEA;

    typedef enum logic [1:0] {
        FUNC_CPU_READ  = 2'd0,
        FUNC_CPU_WRITE = 2'd1,
        FUNC_HOST_IO   = 2'd2,
        FUNC_HOST_ROM  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_RAM_ENABLE = 2'd0,
        CFG_IO_ENABLE  = 2'd1,
        CFG_ROM_ENABLE = 2'd2,
        CFG_LOG_ENABLE = 2'd3
    } cfg_idx_t;

    // Which store feeds read_byte
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_IO   = 2'd1,
        SRC_RAM  = 2'd2,
        SRC_ROM  = 2'd3
    } src_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        drive_bus;
        logic        log_valid;
        logic [15:0] log_address;
        logic [7:0]  log_byte;
    } out_item_t;

    typedef struct packed {
        logic ram_enable;
        logic io_enable;
        logic rom_enable;
        logic log_enable;
    } cfg_t;

    // Per-store access plan for one beat
    typedef struct packed {
        logic        io_en;
        logic        io_we;
        logic [15:0] io_off;
        logic        ram_en;
        logic        ram_we;
        logic [15:0] ram_off;
        logic        rom_en;
        logic        rom_we;
        logic [15:0] rom_off;
        src_t        src;
        logic        log_valid;
    } dec_t;

endpackage

`default_nettype wire

@@ hdl/bmm_store.sv @@
`default_nettype none

module bmm_store
    import bmm_pkg::*;
#(
    parameter int          DEPTH = 8192,
    parameter logic [7:0]  FILL  = 8'h00,
    localparam int         AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic [7:0]         rdata,
    output logic               ready
);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;
    logic          clr_busy_reg;
    logic          clr_busy_next;

    // Clearing sweep: one entry per cycle after reset
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= FILL;
        end
        else if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

    assign ready = !clr_busy_reg;

endmodule

`default_nettype wire

@@ hdl/bmm_decode.sv @@
`default_nettype none

module bmm_decode
    import bmm_pkg::*;
#(
    parameter int RAM_BYTES = 39936,
    parameter int IO_BYTES  = 8192,
    parameter int ROM_BYTES = 32768
)
(
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output dec_t          dec
);

    logic [15:0] a;
    logic [15:0] io_off;
    logic [15:0] ram_off;
    logic [15:0] rom_off;
    logic [15:0] host_io_off;
    logic        io_hit;
    logic        ram_hit;
    logic        rom_hit;

    assign a           = item.bus_address;
    assign io_off      = a - IO_LO;
    assign ram_off     = a - RAM_LO;
    assign rom_off     = a - ROM_LO;
    assign host_io_off = a & HOST_IO_MASK;

    // A store smaller than its window only answers inside its size
    assign io_hit  = cfg.io_enable && (a >= IO_LO) && (a <= IO_HI)
                     && ({16'd0, io_off} < 32'(IO_BYTES));
    assign ram_hit = cfg.ram_enable && (a <= RAM_HI)
                     && ({16'd0, ram_off} < 32'(RAM_BYTES));
    assign rom_hit = cfg.rom_enable && (a >= ROM_LO)
                     && ({16'd0, rom_off} < 32'(ROM_BYTES));

    always_comb
    begin
        dec         = '0;
        dec.src     = SRC_NONE;
        dec.io_off  = io_off;
        dec.ram_off = ram_off;
        dec.rom_off = rom_off;
        unique case (func_t'(item.func))
            FUNC_CPU_READ:
            begin
                priority if (io_hit)
                begin
                    dec.io_en = 1'b1;
                    dec.src   = SRC_IO;
                end
                else if (ram_hit)
                begin
                    dec.ram_en = 1'b1;
                    dec.src    = SRC_RAM;
                end
                else if (rom_hit)
                begin
                    dec.rom_en = 1'b1;
                    dec.src    = SRC_ROM;
                end
                else
                begin
                    dec.src = SRC_NONE;
                end
            end
            FUNC_CPU_WRITE:
            begin
                priority if (io_hit)
                begin
                    dec.io_en     = 1'b1;
                    dec.io_we     = 1'b1;
                    dec.log_valid = cfg.log_enable;
                end
                else if (ram_hit)
                begin
                    dec.ram_en = 1'b1;
                    dec.ram_we = 1'b1;
                end
                else
                begin
                    dec.ram_en = 1'b0;
                end
            end
            FUNC_HOST_IO:
            begin
                dec.io_off = host_io_off;
                dec.io_en  = ({16'd0, host_io_off} < 32'(IO_BYTES));
                dec.io_we  = 1'b1;
            end
            FUNC_HOST_ROM:
            begin
                dec.rom_off = a;
                dec.rom_en  = ({16'd0, a} < 32'(ROM_BYTES));
                dec.rom_we  = 1'b1;
            end
            default:
            begin
                dec.src = SRC_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/bus_memory_map_responder.sv @@
// channel | dir | handshake         | payload
// --------+-----+-------------------+-------------------------------------------
// in      | in  | in_valid/in_stall | in_item: func, bus_address, write_byte
// out     | out | out_valid/out_stall| out_item: read_byte, drive_bus, log fields
// cfg     | in  | cfg_we            | cfg_index, cfg_data (bit 0 kept)
//
// One beat per cycle sustained while out_stall is low. The store is read on the
// accepting edge as the beat enters stage 1; the output register loads from stage 1
// when it is empty or out_stall is low, and out_valid rises with that load. After reset
// all three stores are swept to their reset value in parallel, one entry per cycle.
// in_stall is high during the sweep and when a finished beat cannot move into
// a stalled, full output register. Config writes are taken at any time.
`default_nettype none

module bus_memory_map_responder
    import bmm_pkg::*;
#(
    parameter int RAM_BYTES = 39936,
    parameter int IO_BYTES  = 8192,
    parameter int ROM_BYTES = 32768
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_item,
    input  wire logic      cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic      cfg_data
);

    localparam int RAM_AW = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
    localparam int IO_AW  = (IO_BYTES > 1) ? $clog2(IO_BYTES) : 1;
    localparam int ROM_AW = (ROM_BYTES > 1) ? $clog2(ROM_BYTES) : 1;

    cfg_t        cfg_reg;
    dec_t        dec;
    logic        accept;
    logic        clearing;
    logic        s1_move;
    logic        io_ready;
    logic        ram_ready;
    logic        rom_ready;
    logic [7:0]  io_rdata;
    logic [7:0]  ram_rdata;
    logic [7:0]  rom_rdata;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    src_t        s1_src_reg;
    logic        s1_log_reg;
    logic [15:0] s1_addr_reg;
    logic [7:0]  s1_byte_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_item_reg;
    out_item_t   out_item_next;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ram_enable <= 1'b1;
            cfg_reg.io_enable  <= 1'b1;
            cfg_reg.rom_enable <= 1'b1;
            cfg_reg.log_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RAM_ENABLE: cfg_reg.ram_enable <= cfg_data;
                CFG_IO_ENABLE:  cfg_reg.io_enable  <= cfg_data;
                CFG_ROM_ENABLE: cfg_reg.rom_enable <= cfg_data;
                CFG_LOG_ENABLE: cfg_reg.log_enable <= cfg_data;
                default:        cfg_reg.log_enable <= cfg_reg.log_enable;
            endcase
        end
    end

    bmm_decode #(
        .RAM_BYTES (RAM_BYTES),
        .IO_BYTES  (IO_BYTES),
        .ROM_BYTES (ROM_BYTES)
    ) u_decode (
        .item (in_item),
        .cfg  (cfg_reg),
        .dec  (dec)
    );

    bmm_store #(
        .DEPTH (IO_BYTES),
        .FILL  (IO_FILL)
    ) u_io_store (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept && dec.io_en),
        .we    (dec.io_we),
        .addr  (dec.io_off[IO_AW-1:0]),
        .wdata (in_item.write_byte),
        .rdata (io_rdata),
        .ready (io_ready)
    );

    bmm_store #(
        .DEPTH (RAM_BYTES),
        .FILL  (RAM_FILL)
    ) u_ram_store (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept && dec.ram_en),
        .we    (dec.ram_we),
        .addr  (dec.ram_off[RAM_AW-1:0]),
        .wdata (in_item.write_byte),
        .rdata (ram_rdata),
        .ready (ram_ready)
    );

    bmm_store #(
        .DEPTH (ROM_BYTES),
        .FILL  (ROM_FILL)
    ) u_rom_store (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept && dec.rom_en),
        .we    (dec.rom_we),
        .addr  (dec.rom_off[ROM_AW-1:0]),
        .wdata (in_item.write_byte),
        .rdata (rom_rdata),
        .ready (rom_ready)
    );

    assign clearing = !(io_ready && ram_ready && rom_ready);
    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clearing || (s1_valid_reg && !s1_move);
    assign accept   = in_valid && !in_stall;

    // Stage 1: beat waits here while its store read completes
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_src_reg  <= dec.src;
            s1_log_reg  <= dec.log_valid;
            s1_addr_reg <= in_item.bus_address;
            s1_byte_reg <= in_item.write_byte;
        end
    end

    // Output register
    always_comb
    begin
        out_item_next             = '0;
        out_item_next.drive_bus   = (s1_src_reg != SRC_NONE);
        out_item_next.log_valid   = s1_log_reg;
        out_item_next.log_address = s1_log_reg ? s1_addr_reg : 16'd0;
        out_item_next.log_byte    = s1_log_reg ? s1_byte_reg : 8'd0;
        unique case (s1_src_reg)
            SRC_IO:   out_item_next.read_byte = io_rdata;
            SRC_RAM:  out_item_next.read_byte = ram_rdata;
            SRC_ROM:  out_item_next.read_byte = rom_rdata;
            SRC_NONE: out_item_next.read_byte = 8'd0;
            default:  out_item_next.read_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_no_drive_and_log: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.drive_bus && out_item.log_valid))
        else $error("read result carries a log report");

    a_undriven_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.drive_bus) |-> (out_item.read_byte == 8'd0))
        else $error("undriven beat has nonzero read_byte");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted beat lost before stage 1");

    a_s1_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("stage 1 beat did not reach output register");

    a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!s1_valid_reg && !out_valid_reg))
        else $error("beat in flight during store clearing sweep");

endmodule

`default_nettype wire
